[src/sharded_quota_counter_assert.svh]
// ----------------------------------------------------------------------------
// Sharded quota counter assertion macros
// Short forms for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef SHARDED_QUOTA_COUNTER_ASSERT_SVH
`define SHARDED_QUOTA_COUNTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SQC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SQC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sqc_pkg.sv]
// ----------------------------------------------------------------------------
// sqc_pkg
// Shared constants and command codes of the sharded quota counter.
// ----------------------------------------------------------------------------
package sqc_pkg;

  localparam int MAX_SHARDS_DEF  = 64;
  localparam int AMOUNT_BITS_DEF = 32;

  localparam logic [1:0] CMD_APPLY = 2'd0;
  localparam logic [1:0] CMD_MARK  = 2'd1;
  localparam logic [1:0] CMD_SEED  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_COUNT = 1'b1;

endpackage

[src/sharded_quota_counter.sv]
// ----------------------------------------------------------------------------
// sharded_quota_counter
// Splits a global limit over up to MAX_SHARDS shards and serves apply, mark
// and seed requests against a per-shard used amount held in one memory.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  input     | start && !busy         | in_command, in_key_id, in_amount
//  result    | out_valid (one cycle)  | out_success, out_shard_used,
//            |                        | out_shard_index, out_total_used,
//            |                        | out_exhausted_count
//  config    | psel&penable&pwrite    | paddr, pwdata (limit at 0, count at 4)
//
// An apply or mark request passes S_DIV, where a bit-serial divider over
// DW = max(AMOUNT_BITS, 32) bits reduces the key modulo the shard count,
// then S_RD and S_EXEC. A seed request within the limit adds a write sweep
// over the active shards in S_SEED.
// After reset and after every register write the block stays busy while it
// divides the limit (S_IDIV, S_IFIN) and then clears the memory (S_CLR).
// Results cannot be stalled; busy stays low in the cycle of the strobe.
// ----------------------------------------------------------------------------
module sharded_quota_counter #(
  parameter int MAX_SHARDS  = sqc_pkg::MAX_SHARDS_DEF,
  parameter int AMOUNT_BITS = sqc_pkg::AMOUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key_id,
  input  logic [31:0] in_amount,
  output logic        out_valid,
  output logic        out_success,
  output logic [31:0] out_shard_used,
  output logic [5:0]  out_shard_index,
  output logic [31:0] out_total_used,
  output logic [6:0]  out_exhausted_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = AMOUNT_BITS;
  localparam int DW    = (AW > 32) ? AW : 32;
  localparam int IDX_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int CNT_W = $clog2(MAX_SHARDS + 1);
  localparam int SW    = $clog2(DW + 1);
  localparam int MW    = AW + 1;

  typedef enum logic [2:0] {
    S_IDIV, S_IFIN, S_CLR, S_IDLE, S_DIV, S_RD, S_EXEC, S_SEED
  } state_t;

  state_t state_r;

  logic [31:0]      limit_r;
  logic [6:0]       count_r;
  logic [1:0]       cmd_r;
  logic [AW-1:0]    amt_r;
  logic [IDX_W-1:0] sel_r;
  logic [DW-1:0]    dvd_r;
  logic [CNT_W-1:0] rem_r;
  logic [SW-1:0]    step_r;
  logic [AW-1:0]    base_r;
  logic [CNT_W-1:0] extra_r;
  logic [CNT_W-1:0] full_r;
  logic [AW-1:0]    total_r;
  logic [IDX_W-1:0] idx_r;
  logic [AW-1:0]    left_r;
  logic [AW-1:0]    selused_r;

  logic             out_valid_r;
  logic             out_success_r;
  logic [AW-1:0]    out_used_r;
  logic [IDX_W-1:0] out_index_r;
  logic [AW-1:0]    out_total_r;
  logic [CNT_W-1:0] out_full_r;

  // Shard memory: flag in the top bit, used amount below it.
  logic [MW-1:0]    mem [MAX_SHARDS];
  logic [MW-1:0]    rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [MW-1:0]    mem_wd;

  logic             cfg_wr;
  logic [CNT_W-1:0] n_eff;
  logic [AW-1:0]    lim_m;
  logic [CNT_W:0]   div_t;
  logic             div_ge;
  logic [CNT_W-1:0] rem_nxt;
  logic [DW-1:0]    dvd_nxt;
  logic             div_last;

  logic [AW-1:0]    cur;
  logic             ann;
  logic [AW-1:0]    res;
  logic             apply_ok;
  logic             mark_ok;
  logic [AW-1:0]    used_nxt;
  logic [AW-1:0]    total_nxt;
  logic [CNT_W-1:0] full_nxt;

  logic [AW-1:0]    seed_r;
  logic [AW-1:0]    seed_a;
  logic             seed_full;
  logic [AW-1:0]    left_nxt;
  logic [CNT_W-1:0] seed_full_nxt;
  logic             seed_last;
  logic [AW-1:0]    seed_sel_used;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sqc_pkg::REG_LIMIT) ? limit_r : 32'(count_r);
  assign lim_m  = AW'(limit_r);

  always_comb begin
    if (count_r == 7'd0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_r) > 32'(MAX_SHARDS)) begin
      n_eff = CNT_W'(MAX_SHARDS);
    end else begin
      n_eff = CNT_W'(count_r);
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    div_t    = {rem_r, dvd_r[DW-1]};
    div_ge   = div_t >= {1'b0, n_eff};
    rem_nxt  = div_ge ? CNT_W'(div_t - {1'b0, n_eff}) : CNT_W'(div_t);
    dvd_nxt  = {dvd_r[DW-2:0], div_ge};
    div_last = step_r == SW'(DW - 1);
  end

  always_comb begin
    cur       = rd_q[AW-1:0];
    ann       = rd_q[AW];
    res       = AW'(base_r + AW'(CNT_W'(sel_r) < extra_r));
    apply_ok  = (cur <= res) && (amt_r <= AW'(res - cur));
    mark_ok   = (cur == res) && !ann;
    used_nxt  = AW'(cur + amt_r);
    total_nxt = AW'(total_r + amt_r);
    full_nxt  = full_r + CNT_W'((cur != res) && (used_nxt == res));

    seed_r        = AW'(base_r + AW'(CNT_W'(idx_r) < extra_r));
    seed_a        = (left_r < seed_r) ? left_r : seed_r;
    seed_full     = seed_a == seed_r;
    left_nxt      = AW'(left_r - seed_a);
    seed_full_nxt = full_r + CNT_W'(seed_full);
    seed_last     = CNT_W'(idx_r) == CNT_W'(n_eff - CNT_W'(1));
    seed_sel_used = (idx_r == sel_r) ? seed_a : selused_r;
  end

  always_comb begin
    rd_addr = IDX_W'(rem_r);
    mem_we  = 1'b0;
    mem_wa  = idx_r;
    mem_wd  = '0;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        mem_wa = sel_r;
        if (cmd_r == sqc_pkg::CMD_APPLY && apply_ok) begin
          mem_we = 1'b1;
          mem_wd = {ann, used_nxt};
        end else if (cmd_r == sqc_pkg::CMD_MARK && mark_ok) begin
          mem_we = 1'b1;
          mem_wd = {1'b1, cur};
        end
      end
      S_SEED: begin
        mem_we = 1'b1;
        mem_wd = {seed_full, seed_a};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDIV;
      limit_r     <= '0;
      count_r     <= 7'd1;
      dvd_r       <= '0;
      rem_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        // Any register write restarts the share division and the clear sweep.
        if (paddr[2] == sqc_pkg::REG_LIMIT) begin
          limit_r <= pwdata;
          dvd_r   <= DW'(AW'(pwdata));
        end else begin
          count_r <= pwdata[6:0];
          dvd_r   <= DW'(lim_m);
        end
        rem_r   <= '0;
        step_r  <= '0;
        state_r <= S_IDIV;
      end else begin
        unique case (state_r)
          S_IDIV: begin
            dvd_r  <= dvd_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r + SW'(1);
            if (div_last) begin
              state_r <= S_IFIN;
            end
          end
          S_IFIN: begin
            base_r  <= AW'(dvd_r);
            extra_r <= rem_r;
            full_r  <= (AW'(dvd_r) == '0) ? CNT_W'(n_eff - rem_r) : '0;
            total_r <= '0;
            idx_r   <= '0;
            state_r <= S_CLR;
          end
          S_CLR: begin
            idx_r <= idx_r + IDX_W'(1);
            if (idx_r == IDX_W'(MAX_SHARDS - 1)) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start) begin
              cmd_r   <= in_command;
              amt_r   <= AW'(in_amount);
              dvd_r   <= DW'(in_key_id);
              rem_r   <= '0;
              step_r  <= '0;
              state_r <= S_DIV;
            end
          end
          S_DIV: begin
            dvd_r  <= dvd_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r + SW'(1);
            if (div_last) begin
              state_r <= S_RD;
            end
          end
          S_RD: begin
            sel_r   <= IDX_W'(rem_r);
            state_r <= S_EXEC;
          end
          S_EXEC: begin
            out_index_r   <= sel_r;
            out_success_r <= 1'b0;
            out_used_r    <= cur;
            out_total_r   <= total_r;
            out_full_r    <= full_r;
            state_r       <= S_IDLE;
            out_valid_r   <= 1'b1;
            unique case (cmd_r)
              sqc_pkg::CMD_APPLY: begin
                if (apply_ok) begin
                  total_r       <= total_nxt;
                  full_r        <= full_nxt;
                  out_success_r <= 1'b1;
                  out_used_r    <= used_nxt;
                  out_total_r   <= total_nxt;
                  out_full_r    <= full_nxt;
                end
              end
              sqc_pkg::CMD_MARK: begin
                out_success_r <= mark_ok;
              end
              sqc_pkg::CMD_SEED: begin
                if (amt_r <= lim_m) begin
                  // Greedy refill sweep; the result goes out at its end.
                  idx_r       <= '0;
                  left_r      <= amt_r;
                  full_r      <= '0;
                  selused_r   <= '0;
                  out_valid_r <= 1'b0;
                  state_r     <= S_SEED;
                end
              end
              default: begin
                out_success_r <= 1'b0;
              end
            endcase
          end
          S_SEED: begin
            idx_r     <= idx_r + IDX_W'(1);
            left_r    <= left_nxt;
            full_r    <= seed_full_nxt;
            selused_r <= seed_sel_used;
            if (seed_last) begin
              total_r       <= AW'(amt_r - left_nxt);
              out_success_r <= left_nxt == '0;
              out_used_r    <= seed_sel_used;
              out_total_r   <= AW'(amt_r - left_nxt);
              out_full_r    <= seed_full_nxt;
              out_valid_r   <= 1'b1;
              state_r       <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign busy                = state_r != S_IDLE;
  assign out_valid           = out_valid_r;
  assign out_success         = out_success_r;
  assign out_shard_used      = 32'(out_used_r);
  assign out_shard_index     = 6'(out_index_r);
  assign out_total_used      = 32'(out_total_r);
  assign out_exhausted_count = 7'(out_full_r);

endmodule

[src/sqc_checker.sv]
// ----------------------------------------------------------------------------
// sqc_checker
// Port-level checks of the sharded quota counter request and result timing.
// ----------------------------------------------------------------------------
`include "sharded_quota_counter_assert.svh"

module sqc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted request keeps the block busy in the cycle after it is taken.
  `SQC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")
  // One strobe per request: results never come in adjacent cycles.
  `SQC_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "double result strobe")
  // The result cycle is also the first cycle in which a new request can enter.
  `SQC_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid, !busy, "result while busy")

endmodule

bind sharded_quota_counter sqc_checker u_sqc_checker (.*);
